@@ rtl/array_linked_list_engine_defines.svh @@
// assertion macros shared by the list engine rtl
`ifndef ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH

// check holds in the same cycle as cond
`define ALLE_ASSERT_NOW(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error(msg);

// check holds in the cycle after cond
`define ALLE_ASSERT_NEXT(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error(msg);

`endif

@@ rtl/alle_pkg.sv @@
// types and codes of the array linked list engine
package alle_pkg;

   localparam logic [2:0] MODE_INS_AFTER  = 3'd0;
   localparam logic [2:0] MODE_INS_BEFORE = 3'd1;
   localparam logic [2:0] MODE_DELETE     = 3'd2;
   localparam logic [2:0] MODE_COMPACT    = 3'd3;
   localparam logic [2:0] MODE_READ       = 3'd4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_ANCHOR = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;
   localparam logic [1:0] STATUS_BAD_TARGET = 2'd3;

   typedef struct packed {
      logic [7:0]         result_slot;
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [7:0]         read_next;
      logic [7:0]         read_prev;
      logic [7:0]         item_count;
   } rsp_type;

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_RD1      = 20'h00002,
      ST_RD_ANC   = 20'h00004,
      ST_RD_FREE  = 20'h00008,
      ST_RD_SUCC  = 20'h00010,
      ST_WR_I1    = 20'h00020,
      ST_WR_I2    = 20'h00040,
      ST_WR_I3    = 20'h00080,
      ST_RD_P     = 20'h00100,
      ST_RD_Q     = 20'h00200,
      ST_WR_D1    = 20'h00400,
      ST_WR_D2    = 20'h00800,
      ST_WR_D3    = 20'h01000,
      ST_WALK_CHK = 20'h02000,
      ST_WALK_RD  = 20'h04000,
      ST_COPY_CHK = 20'h08000,
      ST_COPY_WR  = 20'h10000,
      ST_HEAD     = 20'h20000,
      ST_CLEAR    = 20'h40000,
      ST_DONE     = 20'h80000
   } state_type;

endpackage

@@ rtl/alle_rsp_buf.sv @@
// output register of the result channel
module alle_rsp_buf
   import alle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rsp_type            load_data,
   output logic               ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_result_slot,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [7:0]         rsp_read_next,
   output logic [7:0]         rsp_read_prev,
   output logic [7:0]         rsp_item_count
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_slot = data_ff.result_slot;
   assign rsp_status      = data_ff.status;
   assign rsp_read_value  = data_ff.read_value;
   assign rsp_read_next   = data_ff.read_next;
   assign rsp_read_prev   = data_ff.read_prev;
   assign rsp_item_count  = data_ff.item_count;

endmodule

@@ rtl/array_linked_list_engine.sv @@
// circular doubly linked list engine over slot memories
// ops read the links they need, write any changed links, then wait in ST_DONE
// compact: walk into the buffer half, copy back to slots 1..n, sweep the rest free, n = items
// one operation at a time; req_stall is high whenever the engine is not idle
// reset: a sweep over the slots rebuilds the free chain, req_stall high meanwhile
// the result register lets the next transfer be taken while a result waits
module array_linked_list_engine
   import alle_pkg::*;
#(
   parameter int CAPACITY = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_slot_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_result_slot,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [7:0]         rsp_read_next,
   output logic [7:0]         rsp_read_prev,
   output logic [7:0]         rsp_item_count
);

`include "array_linked_list_engine_defines.svh"

   localparam int SW  = $clog2(CAPACITY);
   localparam int NW  = SW + 1;
   localparam int DAW = SW + 1;
   localparam logic [NW-1:0] NONE = NW'(CAPACITY);

   typedef struct packed {
      logic          used;
      logic [SW-1:0] prev;
      logic [NW-1:0] nxt;
   } link_type;

   // link memory
   link_type      lk_mem [CAPACITY];
   link_type      lk_rd_ff, lk_wd;
   logic          lk_we;
   logic [SW-1:0] lk_wa, lk_ra;

   // data memory: lower half slots, upper half compaction buffer
   logic [31:0]    dt_mem [2*CAPACITY];
   logic [31:0]    dt_rd_ff, dt_wd;
   logic           dt_we;
   logic [DAW-1:0] dt_wa, dt_ra;

   always_ff @(posedge clock) begin
      if (lk_we) begin
         lk_mem[lk_wa] <= lk_wd;
      end
      lk_rd_ff <= lk_mem[lk_ra];
   end

   always_ff @(posedge clock) begin
      if (dt_we) begin
         dt_mem[dt_wa] <= dt_wd;
      end
      dt_rd_ff <= dt_mem[dt_ra];
   end

   state_type     st_ff, st_in;
   logic          boot_ff, boot_in;
   logic [2:0]    mode_ff, mode_in;
   logic [7:0]    idx_ff, idx_in;
   logic [31:0]   value_ff, value_in;
   logic [SW-1:0] anchor_ff, anchor_in;
   logic [SW-1:0] succ_ff, succ_in;
   logic [SW-1:0] fresh_ff, fresh_in;
   link_type      aw_ff, aw_in;
   link_type      sw_ff, sw_in;
   logic [NW-1:0] fnext_ff, fnext_in;
   logic [NW-1:0] free_head_ff, free_head_in;
   logic [SW-1:0] count_ff, count_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] i_ff, i_in;
   rsp_type       res_ff, res_in;

   logic          buf_ready, buf_load;
   rsp_type       buf_data;
   logic          idx_in_range, idx_live, free_empty, ins_done;
   logic [SW-1:0] idx_slot;

   assign idx_in_range = {24'd0, idx_ff} < 32'(CAPACITY);
   assign idx_slot     = SW'(idx_ff);
   assign idx_live     = idx_in_range && lk_rd_ff.used;
   assign free_empty   = free_head_ff >= NONE;

   always_comb begin
      st_in        = st_ff;
      boot_in      = boot_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      anchor_in    = anchor_ff;
      succ_in      = succ_ff;
      fresh_in     = fresh_ff;
      aw_in        = aw_ff;
      sw_in        = sw_ff;
      fnext_in     = fnext_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      res_in       = res_ff;
      lk_we        = 1'b0;
      lk_wa        = '0;
      lk_wd        = '0;
      lk_ra        = '0;
      dt_we        = 1'b0;
      dt_wa        = '0;
      dt_wd        = '0;
      dt_ra        = '0;
      buf_load     = 1'b0;
      ins_done     = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            lk_ra = (req_mode == MODE_COMPACT) ? '0 : SW'(req_slot_index);
            dt_ra = DAW'(SW'(req_slot_index));
            if (req_valid) begin
               mode_in  = req_mode;
               idx_in   = req_slot_index;
               value_in = req_value;
               st_in    = ST_RD1;
            end
         end
         ST_RD1: begin
            res_in             = '0;
            res_in.result_slot = idx_ff;
            res_in.status      = STATUS_OK;
            st_in              = ST_DONE;
            unique case (mode_ff)
               MODE_INS_AFTER: begin
                  if (!idx_live) begin
                     res_in.status = STATUS_BAD_ANCHOR;
                  end else if (free_empty) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     anchor_in = idx_slot;
                     aw_in     = lk_rd_ff;
                     fresh_in  = SW'(free_head_ff);
                     lk_ra     = SW'(free_head_ff);
                     st_in     = ST_RD_FREE;
                  end
               end
               MODE_INS_BEFORE: begin
                  if (!idx_live) begin
                     res_in.status = STATUS_BAD_ANCHOR;
                  end else begin
                     anchor_in = lk_rd_ff.prev;
                     lk_ra     = lk_rd_ff.prev;
                     st_in     = ST_RD_ANC;
                  end
               end
               MODE_DELETE: begin
                  if (!idx_live || idx_ff == 8'd0) begin
                     res_in.status = STATUS_BAD_TARGET;
                  end else begin
                     anchor_in = lk_rd_ff.prev;
                     succ_in   = SW'(lk_rd_ff.nxt);
                     lk_ra     = lk_rd_ff.prev;
                     st_in     = ST_RD_P;
                  end
               end
               MODE_COMPACT: begin
                  cur_in = lk_rd_ff.nxt;
                  n_in   = '0;
                  st_in  = ST_WALK_CHK;
               end
               MODE_READ: begin
                  if (!idx_live) begin
                     res_in.status = STATUS_BAD_TARGET;
                  end else begin
                     res_in.read_value = (idx_ff == 8'd0) ? 32'sd0 : dt_rd_ff;
                     res_in.read_next  = 8'(lk_rd_ff.nxt);
                     res_in.read_prev  = 8'(lk_rd_ff.prev);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RD_ANC: begin
            if (free_empty) begin
               res_in.status = STATUS_FULL;
               st_in         = ST_DONE;
            end else begin
               aw_in    = lk_rd_ff;
               fresh_in = SW'(free_head_ff);
               lk_ra    = SW'(free_head_ff);
               st_in    = ST_RD_FREE;
            end
         end
         ST_RD_FREE: begin
            fnext_in = lk_rd_ff.nxt;
            succ_in  = SW'(aw_ff.nxt);
            lk_ra    = SW'(aw_ff.nxt);
            st_in    = ST_RD_SUCC;
         end
         ST_RD_SUCC: begin
            sw_in = lk_rd_ff;
            st_in = ST_WR_I1;
         end
         ST_WR_I1: begin
            lk_we      = 1'b1;
            lk_wa      = fresh_ff;
            lk_wd.used = 1'b1;
            lk_wd.prev = anchor_ff;
            lk_wd.nxt  = NW'(succ_ff);
            dt_we      = 1'b1;
            dt_wa      = DAW'(fresh_ff);
            dt_wd      = value_ff;
            st_in      = ST_WR_I2;
         end
         ST_WR_I2: begin
            // successor gets its new predecessor; an empty list merges both edits
            lk_we      = 1'b1;
            lk_wa      = succ_ff;
            lk_wd      = sw_ff;
            lk_wd.prev = fresh_ff;
            if (succ_ff == anchor_ff) begin
               lk_wd.nxt = NW'(fresh_ff);
               ins_done  = 1'b1;
            end else begin
               st_in = ST_WR_I3;
            end
         end
         ST_WR_I3: begin
            lk_we     = 1'b1;
            lk_wa     = anchor_ff;
            lk_wd     = aw_ff;
            lk_wd.nxt = NW'(fresh_ff);
            ins_done  = 1'b1;
         end
         ST_RD_P: begin
            aw_in = lk_rd_ff;
            lk_ra = succ_ff;
            st_in = ST_RD_Q;
         end
         ST_RD_Q: begin
            sw_in = lk_rd_ff;
            st_in = ST_WR_D1;
         end
         ST_WR_D1: begin
            lk_we     = 1'b1;
            lk_wa     = anchor_ff;
            lk_wd     = aw_ff;
            lk_wd.nxt = NW'(succ_ff);
            if (anchor_ff == succ_ff) begin
               lk_wd.prev = anchor_ff;
               st_in      = ST_WR_D3;
            end else begin
               st_in = ST_WR_D2;
            end
         end
         ST_WR_D2: begin
            lk_we      = 1'b1;
            lk_wa      = succ_ff;
            lk_wd      = sw_ff;
            lk_wd.prev = anchor_ff;
            st_in      = ST_WR_D3;
         end
         ST_WR_D3: begin
            lk_we        = 1'b1;
            lk_wa        = idx_slot;
            lk_wd.used   = 1'b0;
            lk_wd.prev   = '0;
            lk_wd.nxt    = free_head_ff;
            free_head_in = NW'(idx_slot);
            count_in     = count_ff - 1'b1;
            st_in        = ST_DONE;
         end
         ST_WALK_CHK: begin
            if (cur_ff == '0 || cur_ff >= NONE || n_ff >= NONE) begin
               n_in  = (n_ff >= NONE) ? NONE - 1'b1 : n_ff;
               i_in  = '0;
               st_in = ST_COPY_CHK;
            end else begin
               lk_ra = SW'(cur_ff);
               dt_ra = DAW'(SW'(cur_ff));
               st_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            dt_we  = 1'b1;
            dt_wa  = DAW'(CAPACITY) + DAW'(n_ff);
            dt_wd  = dt_rd_ff;
            n_in   = n_ff + 1'b1;
            cur_in = lk_rd_ff.nxt;
            st_in  = ST_WALK_CHK;
         end
         ST_COPY_CHK: begin
            if (i_ff == n_ff) begin
               st_in = ST_HEAD;
            end else begin
               dt_ra = DAW'(CAPACITY) + DAW'(i_ff);
               st_in = ST_COPY_WR;
            end
         end
         ST_COPY_WR: begin
            dt_we      = 1'b1;
            dt_wa      = DAW'(i_ff + 1'b1);
            dt_wd      = dt_rd_ff;
            lk_we      = 1'b1;
            lk_wa      = SW'(i_ff + 1'b1);
            lk_wd.used = 1'b1;
            lk_wd.prev = SW'(i_ff);
            lk_wd.nxt  = (i_ff + 1'b1 == n_ff) ? '0 : i_ff + NW'(2);
            i_in       = i_ff + 1'b1;
            st_in      = ST_COPY_CHK;
         end
         ST_HEAD: begin
            lk_we        = 1'b1;
            lk_wa        = '0;
            lk_wd.used   = 1'b1;
            lk_wd.prev   = SW'(n_ff);
            lk_wd.nxt    = (n_ff != '0) ? NW'(1) : '0;
            count_in     = SW'(n_ff);
            i_in         = n_ff + 1'b1;
            free_head_in = n_ff + 1'b1;
            st_in        = ST_CLEAR;
         end
         ST_CLEAR: begin
            // rebuild the free chain in ascending order
            if (i_ff >= NONE) begin
               if (boot_ff) begin
                  boot_in = 1'b0;
                  st_in   = ST_IDLE;
               end else begin
                  st_in = ST_DONE;
               end
            end else begin
               lk_we      = 1'b1;
               lk_wa      = SW'(i_ff);
               lk_wd.used = 1'b0;
               lk_wd.prev = '0;
               lk_wd.nxt  = i_ff + 1'b1;
               i_in       = i_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (buf_ready) begin
               buf_load = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (ins_done) begin
         free_head_in       = fnext_ff;
         count_in           = count_ff + 1'b1;
         res_in.result_slot = 8'(fresh_ff);
         st_in              = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_HEAD;
         boot_ff <= 1'b1;
         n_ff    <= '0;
      end else begin
         st_ff   <= st_in;
         boot_ff <= boot_in;
         n_ff    <= n_in;
      end
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      value_ff     <= value_in;
      anchor_ff    <= anchor_in;
      succ_ff      <= succ_in;
      fresh_ff     <= fresh_in;
      aw_ff        <= aw_in;
      sw_ff        <= sw_in;
      fnext_ff     <= fnext_in;
      free_head_ff <= free_head_in;
      count_ff     <= count_in;
      cur_ff       <= cur_in;
      i_ff         <= i_in;
      res_ff       <= res_in;
   end

   assign req_stall = (st_ff != ST_IDLE);

   always_comb begin
      buf_data            = res_ff;
      buf_data.item_count = 8'(count_ff);
   end

   alle_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (buf_load),
      .load_data       (buf_data),
      .ready           (buf_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_slot (rsp_result_slot),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_read_next   (rsp_read_next),
      .rsp_read_prev   (rsp_read_prev),
      .rsp_item_count  (rsp_item_count)
   );

   `ALLE_ASSERT_NEXT(a_accept_starts_op, req_valid && !req_stall, st_ff == ST_RD1, "accepted transfer did not start an operation")
   `ALLE_ASSERT_NOW(a_count_bound, st_ff == ST_IDLE, count_ff <= SW'(CAPACITY - 1), "item count above capacity")
   `ALLE_ASSERT_NOW(a_fresh_slot_distinct, st_ff == ST_WR_I1, fresh_ff != anchor_ff && fresh_ff != succ_ff, "free slot collides with a live neighbor")

endmodule

@@ tb/alle_list_checker.sv @@
// checker that predicts the list engine results and compares every response transfer
module alle_list_checker
   import alle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_slot_index,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [7:0]         rsp_result_slot,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_read_value,
   input  logic [7:0]         rsp_read_next,
   input  logic [7:0]         rsp_read_prev,
   input  logic [7:0]         rsp_item_count,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 256;
   localparam logic [8:0] NO_SLOT = 9'd256;

   logic [31:0] cell_data [SLOTS];
   logic [8:0]  link_fwd  [SLOTS];
   logic [7:0]  link_back [SLOTS];
   logic        occupied  [SLOTS];
   logic [8:0]  free_top;
   logic [7:0]  list_len;
   rsp_type     expected_rsp [$];

   function automatic bit is_live(logic [7:0] s);
      return occupied[s];
   endfunction

   function automatic void free_tail_from(int s);
      for (int i = s; i < SLOTS; i++) begin
         cell_data[i] = '0;
         link_back[i] = '0;
         occupied[i]  = 1'b0;
         link_fwd[i]  = 9'(i + 1);
      end
      free_top = (s < SLOTS) ? 9'(s) : NO_SLOT;
   endfunction

   task automatic list_reset();
      free_tail_from(1);
      cell_data[0] = '0;
      link_fwd[0]  = '0;
      link_back[0] = '0;
      occupied[0]  = 1'b1;
      list_len     = '0;
   endtask

   function automatic void link_after(logic [7:0] anchor, logic [31:0] val,
                                      inout rsp_type r);
      logic [7:0] fresh;
      logic [7:0] succ;
      if (!is_live(anchor)) begin
         r.status = STATUS_BAD_ANCHOR;
         return;
      end
      if (free_top == NO_SLOT) begin
         r.status = STATUS_FULL;
         return;
      end
      fresh = free_top[7:0];
      free_top = link_fwd[fresh];
      succ = link_fwd[anchor][7:0];
      cell_data[fresh] = val;
      link_back[fresh] = anchor;
      link_fwd[fresh]  = {1'b0, succ};
      occupied[fresh]  = 1'b1;
      link_back[succ]  = fresh;
      link_fwd[anchor] = {1'b0, fresh};
      list_len++;
      r.result_slot = fresh;
   endfunction

   function automatic void compact_list();
      logic [31:0] walked [SLOTS];
      int n;
      int cur;
      n = 0;
      cur = link_fwd[0];
      while (cur != 0 && cur < SLOTS && n < SLOTS) begin
         walked[n] = cell_data[cur];
         n++;
         cur = link_fwd[cur];
      end
      if (n > SLOTS - 1) n = SLOTS - 1;
      for (int i = 0; i < n; i++) begin
         cell_data[i + 1] = walked[i];
         link_fwd[i + 1]  = (i + 1 == n) ? 9'd0 : 9'(i + 2);
         link_back[i + 1] = 8'(i);
         occupied[i + 1]  = 1'b1;
      end
      link_fwd[0]  = (n > 0) ? 9'd1 : 9'd0;
      link_back[0] = 8'(n);
      occupied[0]  = 1'b1;
      list_len     = 8'(n);
      free_tail_from(n + 1);
   endfunction

   function automatic void apply_op(logic [2:0] mode, logic [7:0] idx, logic [31:0] val);
      rsp_type r;
      logic [7:0] p;
      logic [7:0] q;
      r = '0;
      r.result_slot = idx;
      r.status = STATUS_OK;
      case (mode)
         MODE_INS_AFTER: begin
            link_after(idx, val, r);
         end
         MODE_INS_BEFORE: begin
            if (!is_live(idx)) r.status = STATUS_BAD_ANCHOR;
            else link_after(link_back[idx], val, r);
         end
         MODE_DELETE: begin
            if (idx == 0 || !is_live(idx)) begin
               r.status = STATUS_BAD_TARGET;
            end else begin
               p = link_back[idx];
               q = link_fwd[idx][7:0];
               link_fwd[p]    = {1'b0, q};
               link_back[q]   = p;
               cell_data[idx] = '0;
               link_back[idx] = '0;
               occupied[idx]  = 1'b0;
               link_fwd[idx]  = free_top;
               free_top       = {1'b0, idx};
               list_len--;
            end
         end
         MODE_COMPACT: begin
            compact_list();
         end
         MODE_READ: begin
            if (!is_live(idx)) begin
               r.status = STATUS_BAD_TARGET;
            end else begin
               r.read_value = (idx == 0) ? '0 : cell_data[idx];
               r.read_next  = link_fwd[idx][7:0];
               r.read_prev  = link_back[idx];
            end
         end
         default: ;
      endcase
      r.item_count = list_len;
      expected_rsp.push_back(r);
   endfunction

   initial list_reset();

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_result_slot, rsp_status, rsp_read_value, rsp_read_next,
                    rsp_read_prev, rsp_item_count};
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10) $display("unexpected response transfer %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) apply_op(req_mode, req_slot_index, req_value);
      end
      pending <= expected_rsp.size();
   end

endmodule

@@ tb/tb_array_linked_list_engine.sv @@
// top of the list engine testbench: clock, reset, stimulus and verdict
module tb_array_linked_list_engine;
   import alle_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_mode = '0;
   logic [7:0]         req_slot_index = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_result_slot;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_read_value;
   logic [7:0]         rsp_read_next;
   logic [7:0]         rsp_read_prev;
   logic [7:0]         rsp_item_count;
   int                 fail_count;
   int                 pending;
   bit                 no_gaps = 1'b0;
   int                 cycles = 0;

   always #4 clock = ~clock;

   array_linked_list_engine dut (.*);

   alle_list_checker checker_inst (.*);

   always @(posedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 26);
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_op(logic [2:0] mode, logic [7:0] idx, logic [31:0] val);
      while (!no_gaps && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_slot_index <= idx;
      req_value      <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      logic [2:0] mode;
      int insert_bias;
      int hi;
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corner cases on an empty list and a tiny one
      send_op(MODE_COMPACT, 8'd0, 32'd0);
      send_op(MODE_READ, 8'd0, 32'd0);
      send_op(MODE_READ, 8'd1, 32'd0);
      send_op(MODE_DELETE, 8'd0, 32'd0);
      send_op(MODE_DELETE, 8'd5, 32'd0);
      send_op(MODE_INS_AFTER, 8'd7, 32'd1);
      send_op(MODE_INS_BEFORE, 8'd9, 32'd1);
      send_op(MODE_INS_BEFORE, 8'd0, 32'h7fff_ffff);
      send_op(MODE_INS_AFTER, 8'd0, 32'h8000_0000);
      send_op(MODE_INS_BEFORE, 8'd1, 32'hffff_ffff);
      send_op(MODE_INS_AFTER, 8'd1, 32'd0);
      send_op(MODE_READ, 8'd1, 32'd0);
      send_op(MODE_READ, 8'd0, 32'd0);
      send_op(MODE_READ, 8'd255, 32'd0);
      send_op(3'd5, 8'd255, 32'hffff_ffff);
      send_op(3'd6, 8'd0, 32'd0);
      send_op(3'd7, 8'd170, 32'h5555_5555);
      send_op(MODE_DELETE, 8'd1, 32'd0);
      send_op(MODE_DELETE, 8'd255, 32'd0);
      send_op(MODE_COMPACT, 8'd0, 32'd0);
      send_op(MODE_READ, 8'd1, 32'd0);
      send_op(MODE_READ, 8'd2, 32'd0);
      send_op(MODE_INS_AFTER, 8'd255, 32'd3);

      // phases alternate between growing toward full and draining
      for (int n = 0; n < 2000; n++) begin
         if (n % 200 == 0) begin
            insert_bias = (n / 200) % 2 ? 25 : 80;
            no_gaps = (n >= 800 && n < 1000);
         end
         pick = $urandom_range(0, 99);
         if (pick < insert_bias) mode = $urandom_range(0, 1) ? MODE_INS_AFTER : MODE_INS_BEFORE;
         else if (pick < 93) mode = $urandom_range(0, 1) ? MODE_DELETE : MODE_READ;
         else if (pick < 97) mode = MODE_COMPACT;
         else mode = 3'($urandom_range(5, 7));
         case ($urandom_range(0, 3))
            0: hi = 8;
            1: hi = 64;
            default: hi = 255;
         endcase
         send_op(mode, 8'($urandom_range(0, hi)), $urandom());
      end
      req_valid <= 1'b0;
      no_gaps = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
